>>> sv/bfc_pkg.sv
// Shared types, constants and the CRC-16 byte update for the reply frame checker.
`timescale 1ns / 1ps

package bfc_pkg;

  // Default largest reply length that the byte counter tracks before saturating.
  localparam int MAX_FRAME_DEF = 1023;

  // Width of lengths carried in a frame record (covers the largest MAX_FRAME).
  localparam int LEN_W = 16;

  // Bytes around the core: ack, header, two length bytes, two CRC bytes.
  localparam int CORE_OVERHEAD = 6;

  // Depth of the record queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // Frame constants.
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [7:0]  ACK_BYTE = 8'h00;
  localparam logic [7:0]  HDR_BYTE = 8'h80;

  // Result codes reported with each reply.
  typedef enum logic [2:0] {
    ERR_OK       = 3'd0,
    ERR_LENGTH   = 3'd1,
    ERR_ACK      = 3'd2,
    ERR_HEADER   = 3'd3,
    ERR_CORE_LEN = 3'd4,
    ERR_CRC      = 3'd5,
    ERR_SHORT    = 3'd6
  } err_t;

  // Everything the back needs to judge one finished reply.
  typedef struct packed {
    logic [LEN_W-1:0] frame_len;
    logic [9:0]       expect_len;
    logic [7:0]       ack;
    logic [7:0]       header;
    logic [15:0]      declared_len;
    logic [15:0]      core_head;
    logic [15:0]      crc;
    logic [15:0]      tail;
  } frame_rec_t;

  // One byte of CRC-16 (MSB first), unrolled over the eight bit steps.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

>>> sv/bfc_front.sv
// Front of the reply checker: takes bytes, tracks fields and CRC, emits one record per reply.
`timescale 1ns / 1ps

module bfc_front #(
  parameter int MAX_FRAME = bfc_pkg::MAX_FRAME_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          rx_byte,
  input  logic                last_byte,
  input  logic [9:0]          expected_length,
  input  logic                rec_space,
  output logic                rec_push,
  output bfc_pkg::frame_rec_t rec
);

  localparam int CNT_W = $clog2(MAX_FRAME + 1);

  logic [CNT_W-1:0] byte_count, byte_count_next, count_inc;
  logic [15:0]      running_crc, running_crc_next, crc_upd;
  logic [7:0]       ack_byte, ack_byte_next, ack_upd;
  logic [7:0]       header_byte, header_byte_next, header_upd;
  logic [15:0]      declared_length, declared_length_next, decl_upd;
  logic [15:0]      core_head, core_head_next, head_upd;
  logic [15:0]      tail_bytes, tail_bytes_next, tail_upd;
  logic             accept;

  assign in_ready = rec_space;
  assign accept   = in_valid && in_ready;
  assign rec_push = accept && last_byte;

  // Field capture by position, delayed CRC and saturating byte count.
  always_comb begin
    ack_upd    = ack_byte;
    header_upd = header_byte;
    decl_upd   = declared_length;
    head_upd   = core_head;
    crc_upd    = running_crc;
    case (byte_count)
      CNT_W'(0): ack_upd          = rx_byte;
      CNT_W'(1): header_upd       = rx_byte;
      CNT_W'(2): decl_upd[7:0]    = rx_byte;
      CNT_W'(3): decl_upd[15:8]   = rx_byte;
      CNT_W'(4): head_upd[7:0]    = rx_byte;
      CNT_W'(5): head_upd[15:8]   = rx_byte;
      default:   crc_upd          = bfc_pkg::crc_feed(running_crc, tail_bytes[15:8]);
    endcase
    tail_upd  = {tail_bytes[7:0], rx_byte};
    count_inc = (byte_count < CNT_W'(MAX_FRAME)) ? byte_count + 1'b1 : byte_count;
  end

  // Record of the finished reply, built from the values after this byte.
  always_comb begin
    rec.frame_len    = bfc_pkg::LEN_W'(count_inc);
    rec.expect_len   = expected_length;
    rec.ack          = ack_upd;
    rec.header       = header_upd;
    rec.declared_len = decl_upd;
    rec.core_head    = head_upd;
    rec.crc          = crc_upd;
    rec.tail         = tail_upd;
  end

  // Next state: advance on each word, return to the start after the last one.
  always_comb begin
    byte_count_next      = byte_count;
    running_crc_next     = running_crc;
    ack_byte_next        = ack_byte;
    header_byte_next     = header_byte;
    declared_length_next = declared_length;
    core_head_next       = core_head;
    tail_bytes_next      = tail_bytes;
    if (accept) begin
      if (last_byte) begin
        byte_count_next      = '0;
        running_crc_next     = bfc_pkg::CRC_INIT;
        ack_byte_next        = '0;
        header_byte_next     = '0;
        declared_length_next = '0;
        core_head_next       = '0;
        tail_bytes_next      = '0;
      end else begin
        byte_count_next      = count_inc;
        running_crc_next     = crc_upd;
        ack_byte_next        = ack_upd;
        header_byte_next     = header_upd;
        declared_length_next = decl_upd;
        core_head_next       = head_upd;
        tail_bytes_next      = tail_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count      <= '0;
      running_crc     <= bfc_pkg::CRC_INIT;
      ack_byte        <= '0;
      header_byte     <= '0;
      declared_length <= '0;
      core_head       <= '0;
      tail_bytes      <= '0;
    end else begin
      byte_count      <= byte_count_next;
      running_crc     <= running_crc_next;
      ack_byte        <= ack_byte_next;
      header_byte     <= header_byte_next;
      declared_length <= declared_length_next;
      core_head       <= core_head_next;
      tail_bytes      <= tail_bytes_next;
    end
  end

  // A reply always restarts from position zero with a fresh CRC.
  assert property (@(posedge clk) disable iff (rst)
    rec_push |=> (byte_count == '0) && (running_crc == bfc_pkg::CRC_INIT))
    else $error("front did not restart after the last word");

  // The counter never passes its saturation point.
  assert property (@(posedge clk) disable iff (rst)
    byte_count <= CNT_W'(MAX_FRAME))
    else $error("byte count beyond saturation");

endmodule

>>> sv/bfc_queue.sv
// Short record queue that decouples the front from the back.
`timescale 1ns / 1ps

module bfc_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  bfc_pkg::frame_rec_t push_rec,
  output logic                space,
  input  logic                pop,
  output logic                not_empty,
  output bfc_pkg::frame_rec_t head_rec
);

  localparam int DEPTH = bfc_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bfc_pkg::frame_rec_t entries [DEPTH];
  logic [PTR_W-1:0]    wr_ptr, wr_ptr_next, rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0]    count, count_next;

  assign space     = (count < CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head_rec  = entries[rd_ptr];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (push) begin
      wr_ptr_next = (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
    end
    if (pop) begin
      rd_ptr_next = (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
    end
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  assert property (@(posedge clk) disable iff (rst) push |-> space)
    else $error("record pushed into a full queue");

  assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("record popped from an empty queue");

endmodule

>>> sv/bfc_back.sv
// Back of the reply checker: judges each reply record and holds the result word.
`timescale 1ns / 1ps

module bfc_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                rec_valid,
  input  bfc_pkg::frame_rec_t rec,
  output logic                rec_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                frame_ok,
  output logic [2:0]          error_code,
  output logic [9:0]          core_length,
  output logic [7:0]          response_code,
  output logic [7:0]          first_data
);

  localparam logic [bfc_pkg::LEN_W-1:0] OVERHEAD = bfc_pkg::LEN_W'(bfc_pkg::CORE_OVERHEAD);

  bfc_pkg::err_t err;
  logic          is_long;
  logic [9:0]    core_val;
  logic [7:0]    rc_val, fd_val;

  assign rec_pop = rec_valid && (!out_valid || out_ready);

  // Checks in priority order: length, then ack, header, core length and CRC.
  always_comb begin
    is_long  = (rec.frame_len > OVERHEAD);
    core_val = is_long ? rec.declared_len[9:0] : '0;
    rc_val   = is_long ? rec.core_head[7:0] : '0;
    fd_val   = (rec.frame_len > OVERHEAD + 1'b1) ? rec.core_head[15:8] : '0;
    err      = bfc_pkg::ERR_OK;
    if (rec.frame_len != bfc_pkg::LEN_W'(rec.expect_len)) begin
      err = bfc_pkg::ERR_LENGTH;
    end else if (is_long) begin
      if (rec.ack != bfc_pkg::ACK_BYTE) begin
        err = bfc_pkg::ERR_ACK;
      end else if (rec.header != bfc_pkg::HDR_BYTE) begin
        err = bfc_pkg::ERR_HEADER;
      end else if (rec.declared_len != 16'(rec.frame_len - OVERHEAD)) begin
        err = bfc_pkg::ERR_CORE_LEN;
      end else if (rec.crc != {rec.tail[7:0], rec.tail[15:8]}) begin
        err = bfc_pkg::ERR_CRC;
      end
    end else if (rec.frame_len == bfc_pkg::LEN_W'(1)) begin
      if (rec.ack != bfc_pkg::ACK_BYTE) begin
        err = bfc_pkg::ERR_ACK;
      end
    end else begin
      err = bfc_pkg::ERR_SHORT;
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rec_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_pop) begin
      frame_ok      <= (err == bfc_pkg::ERR_OK);
      error_code    <= err;
      core_length   <= core_val;
      response_code <= rc_val;
      first_data    <= fd_val;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (frame_ok == (error_code == bfc_pkg::ERR_OK)))
    else $error("pass flag disagrees with the error code");

endmodule

>>> sv/bootloader_response_frame_checker.sv
// Top level of the bootloader reply frame checker.
`timescale 1ns / 1ps

// Checks one bootloader reply, one received byte per input word, and gives one result word
// when the word marked last_byte arrives. Rate is one byte per clock cycle while the queue
// has space: the front updates the CRC-16 (polynomial 0x1021, start 0xFFFF) a whole byte per
// cycle and captures the ack, header, core length and first two core bytes by position. Each
// finished reply is handed as a record through a two-entry queue to the back, which runs the
// checks in order (length, ack, header, core length, CRC; lengths 2 to 6 are rejected) and
// loads a result register. The record of the last byte is written into the queue before the
// back loads it into the result register. The queue and the result register together hold
// three finished replies; the input stalls whenever both queue entries are taken. Byte counts
// saturate at MAX_FRAME. No clearing pass is needed after reset.
module bootloader_response_frame_checker #(
  parameter int MAX_FRAME = bfc_pkg::MAX_FRAME_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       last_byte,
  input  logic [9:0] expected_length,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       frame_ok,
  output logic [2:0] error_code,
  output logic [9:0] core_length,
  output logic [7:0] response_code,
  output logic [7:0] first_data
);

  bfc_pkg::frame_rec_t push_rec, head_rec;
  logic                rec_push, rec_space, rec_pop, rec_valid;

  bfc_front #(
    .MAX_FRAME(MAX_FRAME)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .rx_byte         (rx_byte),
    .last_byte       (last_byte),
    .expected_length (expected_length),
    .rec_space       (rec_space),
    .rec_push        (rec_push),
    .rec             (push_rec)
  );

  bfc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (rec_push),
    .push_rec  (push_rec),
    .space     (rec_space),
    .pop       (rec_pop),
    .not_empty (rec_valid),
    .head_rec  (head_rec)
  );

  bfc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .rec_valid     (rec_valid),
    .rec           (head_rec),
    .rec_pop       (rec_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .frame_ok      (frame_ok),
    .error_code    (error_code),
    .core_length   (core_length),
    .response_code (response_code),
    .first_data    (first_data)
  );

endmodule

>>> dv/bootloader_response_frame_checker_tb.sv
// Self-checking testbench for the bootloader reply frame checker.
`timescale 1ns / 1ps

module bootloader_response_frame_checker_tb;

  localparam int MAX_FRAME      = bfc_pkg::MAX_FRAME_DEF;
  localparam int RANDOM_BYTES   = 350;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_LIMIT    = 5000;
  localparam int SETTLE_CYCLES  = 10;
  localparam time RUN_LIMIT_NS  = 2_000_000;

  // One verdict as the block reports it for a finished reply.
  typedef struct {
    logic          ok;
    bfc_pkg::err_t err;
    logic [9:0]    core;
    logic [7:0]    rsp;
    logic [7:0]    data0;
  } reply_verdict_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte = 8'h00;
  logic       last_byte = 1'b0;
  logic [9:0] expected_length = 10'd1;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       frame_ok;
  logic [2:0] error_code;
  logic [9:0] core_length;
  logic [7:0] response_code;
  logic [7:0] first_data;

  // Traffic shaping knobs, written with nonblocking assignments at the clock edge.
  logic src_idle_en = 1'b1;
  logic snk_idle_en = 1'b1;
  logic hold_token  = 1'b0;
  logic hold_seen   = 1'b0;
  int   hold_left   = 0;

  int fail_count = 0;
  int bytes_sent = 0;

  // Verdicts still owed by the block, oldest first.
  reply_verdict_t reply_verdicts[$];

  // Reply under construction for the stimulus tasks.
  logic [7:0] frame_bytes[$];

  // Mirror of the block's per-reply state.
  int unsigned rx_count;
  logic [15:0] crc_acc;
  logic [7:0]  seen_ack;
  logic [7:0]  seen_hdr;
  logic [15:0] seen_len;
  logic [15:0] seen_head;
  logic [15:0] tail_pair;

  bootloader_response_frame_checker dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .rx_byte         (rx_byte),
    .last_byte       (last_byte),
    .expected_length (expected_length),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .frame_ok        (frame_ok),
    .error_code      (error_code),
    .core_length     (core_length),
    .response_code   (response_code),
    .first_data      (first_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // CRC-16, polynomial 0x1021, one bit at a time from the MSB of the byte.
  function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = c;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r = {r[14:0], 1'b0};
      if (fb) r = r ^ bfc_pkg::CRC_POLY;
    end
    return r;
  endfunction

  function automatic void clear_reply_state();
    rx_count  = 0;
    crc_acc   = bfc_pkg::CRC_INIT;
    seen_ack  = 8'h00;
    seen_hdr  = 8'h00;
    seen_len  = 16'h0000;
    seen_head = 16'h0000;
    tail_pair = 16'h0000;
  endfunction

  // Advance the mirror by one accepted word and queue a verdict on the last byte.
  function automatic void predict_reply_byte(input logic [7:0] b, input logic lst,
                                             input logic [9:0] el);
    int unsigned    pos;
    int unsigned    len;
    reply_verdict_t v;
    pos = rx_count;
    case (pos)
      0: seen_ack = b;
      1: seen_hdr = b;
      2: seen_len[7:0] = b;
      3: seen_len[15:8] = b;
      4: seen_head[7:0] = b;
      5: seen_head[15:8] = b;
      default: ;
    endcase
    // The CRC trails the stream by two bytes so the trailer is never folded in.
    if (pos >= 6) crc_acc = crc16_byte(crc_acc, tail_pair[15:8]);
    tail_pair = {tail_pair[7:0], b};
    if (rx_count < MAX_FRAME) rx_count++;
    if (!lst) return;

    len     = rx_count;
    v.core  = 10'd0;
    v.rsp   = 8'h00;
    v.data0 = 8'h00;
    if (len > 6) begin
      v.core = seen_len[9:0];
      v.rsp  = seen_head[7:0];
      if (len > 7) v.data0 = seen_head[15:8];
    end

    // Checks in priority order: length, then the frame fields, then the CRC.
    if (len != el) v.err = bfc_pkg::ERR_LENGTH;
    else if (len > 6) begin
      if (seen_ack != bfc_pkg::ACK_BYTE) v.err = bfc_pkg::ERR_ACK;
      else if (seen_hdr != bfc_pkg::HDR_BYTE) v.err = bfc_pkg::ERR_HEADER;
      else if (32'(seen_len) != len - bfc_pkg::CORE_OVERHEAD) v.err = bfc_pkg::ERR_CORE_LEN;
      else if (crc_acc != {tail_pair[7:0], tail_pair[15:8]}) v.err = bfc_pkg::ERR_CRC;
      else v.err = bfc_pkg::ERR_OK;
    end else if (len == 1) begin
      v.err = (seen_ack != bfc_pkg::ACK_BYTE) ? bfc_pkg::ERR_ACK : bfc_pkg::ERR_OK;
    end else begin
      v.err = bfc_pkg::ERR_SHORT;
    end
    v.ok = (v.err == bfc_pkg::ERR_OK);
    reply_verdicts.push_back(v);
    clear_reply_state();
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    fail_count++;
  endtask

  // Send one word, with random idle cycles ahead of it, and wait for the handshake.
  task automatic send_word(input logic [7:0] b, input logic lst, input logic [9:0] el);
    while (src_idle_en && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    rx_byte         <= b;
    last_byte       <= lst;
    expected_length <= el;
    @(negedge clk);
    while (in_ready !== 1'b1) @(negedge clk);
    @(posedge clk);
    predict_reply_byte(b, lst, el);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [9:0] el);
    for (int i = 0; i < frame_bytes.size(); i++) begin
      send_word(frame_bytes[i], i == frame_bytes.size() - 1, el);
    end
  endtask

  // Build a well-formed reply; a negative fill value means random core bytes.
  task automatic build_reply(input int core_len, input int fill);
    logic [15:0] c;
    logic [15:0] dl;
    logic [7:0]  b;
    c  = bfc_pkg::CRC_INIT;
    dl = 16'(core_len);
    frame_bytes.delete();
    frame_bytes.push_back(bfc_pkg::ACK_BYTE);
    frame_bytes.push_back(bfc_pkg::HDR_BYTE);
    frame_bytes.push_back(dl[7:0]);
    frame_bytes.push_back(dl[15:8]);
    for (int i = 0; i < core_len; i++) begin
      b = (fill < 0) ? 8'($urandom) : 8'(fill);
      frame_bytes.push_back(b);
      c = crc16_byte(c, b);
    end
    frame_bytes.push_back(c[7:0]);
    frame_bytes.push_back(c[15:8]);
  endtask

  task automatic send_raw(input logic [7:0] b0, input int n, input logic [9:0] el);
    frame_bytes.delete();
    frame_bytes.push_back(b0);
    for (int i = 1; i < n; i++) frame_bytes.push_back(8'($urandom));
    send_frame(el);
  endtask

  // Bare acks, a length mismatch and the rejected two and six byte lengths.
  task automatic test_short_replies();
    send_raw(8'h00, 1, 10'd1);
    send_raw(8'hFF, 1, 10'd1);
    send_raw(8'h00, 1, 10'd2);
    send_raw(8'h00, 2, 10'd2);
    send_raw(8'h00, 6, 10'd6);
  endtask

  // Smallest good replies, with all-zero and all-one core bytes.
  task automatic test_min_frames();
    build_reply(1, 8'hFF);
    send_frame(10'(frame_bytes.size()));
    build_reply(2, 8'h00);
    send_frame(10'(frame_bytes.size()));
  endtask

  // One broken field at a time on a nine-byte reply.
  task automatic test_field_errors();
    build_reply(3, -1);
    frame_bytes[0] = 8'h01;
    send_frame(10'(frame_bytes.size()));
    build_reply(3, -1);
    frame_bytes[1] = 8'h7F;
    send_frame(10'(frame_bytes.size()));
    build_reply(3, -1);
    frame_bytes[2] = frame_bytes[2] + 8'd1;
    send_frame(10'(frame_bytes.size()));
    build_reply(3, -1);
    frame_bytes[frame_bytes.size() - 1] ^= 8'h80;
    send_frame(10'(frame_bytes.size()));
  endtask

  // A reply that reaches the top of the byte counter and runs one byte past it.
  task automatic test_long_frames();
    build_reply(MAX_FRAME - bfc_pkg::CORE_OVERHEAD + 1, -1);
    send_frame(10'(MAX_FRAME));
  endtask

  // The receiver holds off while bare acks keep coming, so the input must stall.
  task automatic test_backpressure();
    src_idle_en <= 1'b0;
    hold_token  <= ~hold_token;
    for (int i = 0; i < 30; i++) send_raw((i % 3 == 0) ? 8'h5A : 8'h00, 1, 10'd1);
    build_reply(2, -1);
    send_frame(10'(frame_bytes.size()));
  endtask

  // Mostly good replies with random content; the rest is broken or noise.
  task automatic test_random();
    int start;
    int kind;
    int sz;
    int idx;
    logic [9:0] el;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      // A stretch in the middle runs with neither side idling.
      if (bytes_sent - start > 100 && bytes_sent - start < 250) begin
        src_idle_en <= 1'b0;
        snk_idle_en <= 1'b0;
      end else begin
        src_idle_en <= 1'b1;
        snk_idle_en <= 1'b1;
      end
      kind = $urandom_range(99);
      if (kind < 86 && kind >= 78) begin
        sz = $urandom_range(1, 6);
        send_raw(($urandom_range(1) == 0) ? 8'h00 : 8'($urandom), sz, 10'(sz));
      end else if (kind >= 86) begin
        sz = $urandom_range(1, 30);
        el = ($urandom_range(1) == 0) ? 10'(sz) : 10'($urandom_range(1, 1023));
        send_raw(8'($urandom), sz, el);
      end else begin
        build_reply($urandom_range(1, 24), -1);
        sz = frame_bytes.size();
        el = 10'(sz);
        if (kind >= 60 && kind < 70) begin
          idx = $urandom_range(0, sz - 1);
          frame_bytes[idx] ^= 8'(1 << $urandom_range(0, 7));
        end else if (kind >= 70) begin
          el = ($urandom_range(1) == 0) ? 10'(sz + 1) : 10'(sz - 1);
        end
        send_frame(el);
      end
    end
    src_idle_en <= 1'b1;
    snk_idle_en <= 1'b1;
  endtask

  // Result side: random ready, with a long hold-off whenever the token flips.
  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= snk_idle_en ? ($urandom_range(99) >= 30) : 1'b1;
    end
  end

  // Compare each result word taken at the coming edge with the oldest verdict.
  always @(negedge clk) begin
    reply_verdict_t v;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (reply_verdicts.size() == 0) begin
        report_mismatch("result word with no reply outstanding");
      end else begin
        v = reply_verdicts.pop_front();
        if (frame_ok !== v.ok)
          report_mismatch($sformatf("frame_ok %0b, want %0b", frame_ok, v.ok));
        if (error_code !== v.err)
          report_mismatch($sformatf("error_code %0d, want %s", error_code, v.err.name()));
        if (core_length !== v.core)
          report_mismatch($sformatf("core_length %0d, want %0d", core_length, v.core));
        if (response_code !== v.rsp)
          report_mismatch($sformatf("response_code %02h, want %02h", response_code, v.rsp));
        if (first_data !== v.data0)
          report_mismatch($sformatf("first_data %02h, want %02h", first_data, v.data0));
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #(RUN_LIMIT_NS);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int waited;
    clear_reply_state();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_short_replies();
    test_min_frames();
    test_field_errors();
    test_long_frames();
    test_backpressure();
    test_random();

    in_valid <= 1'b0;
    waited = 0;
    while (reply_verdicts.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (reply_verdicts.size() != 0)
      report_mismatch($sformatf("%0d replies never reported", reply_verdicts.size()));

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
